// ----- rtl/core/vrwe_pkg.sv -----
package vrwe_pkg;

	// Top-level sequencer: take a request, wait for the pitch word, then emit writes
	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_PITCH,
		TOP_EMIT
	} top_state_t;

	// Pitch unit: octave search, then restoring division
	typedef enum logic [1:0] {
		PIT_IDLE,
		PIT_OCT,
		PIT_DIV
	} pitch_state_t;

	// Order of the writes in one programming sequence
	typedef enum logic [3:0] {
		W_KEY_OFF,
		W_LOOP_START,
		W_LENGTH,
		W_PITCH,
		W_PAN,
		W_SEND,
		W_FILTER,
		W_VOLUME,
		W_ENVELOPE,
		W_ADDR_LO,
		W_CONTROL,
		W_KEY_ON
	} write_idx_t;

	typedef struct packed {
		logic        done;
		logic [31:0] word;
	} pitch_rsp_t;

	localparam int PITCH_WORD_W = 32;

	// Slot offsets inside the 128-byte voice window
	localparam logic [6:0] SLOT_CONTROL = 7'd0;
	localparam logic [6:0] SLOT_ADDR_LO = 7'd4;
	localparam logic [6:0] SLOT_LOOP    = 7'd8;
	localparam logic [6:0] SLOT_LENGTH  = 7'd12;
	localparam logic [6:0] SLOT_ENV     = 7'd16;
	localparam logic [6:0] SLOT_PITCH   = 7'd24;
	localparam logic [6:0] SLOT_PAN     = 7'd36;
	localparam logic [6:0] SLOT_SEND    = 7'd37;
	localparam logic [6:0] SLOT_FILTER  = 7'd40;
	localparam logic [6:0] SLOT_VOLUME  = 7'd41;

	localparam logic [31:0] KEY_OFF_DATA   = 32'h0000_8000;
	localparam logic [31:0] SEND_LEVEL     = 32'h0000_000f;
	localparam logic [31:0] FILTER_SETTING = 32'h0000_0024;
	localparam logic [31:0] ENV_SETTING    = 32'h0000_001f;
	localparam logic [15:0] KEY_ON_BITS    = 16'hc000;

	// Linear volume to logarithmic attenuation
	localparam logic [7:0] ATTEN_TABLE [256] = '{
		8'd255, 8'd127, 8'd111, 8'd102, 8'd95, 8'd90, 8'd86, 8'd82,
		8'd79, 8'd77, 8'd74, 8'd72, 8'd70, 8'd68, 8'd66, 8'd65,
		8'd63, 8'd62, 8'd61, 8'd59, 8'd58, 8'd57, 8'd56, 8'd55,
		8'd54, 8'd53, 8'd52, 8'd51, 8'd50, 8'd50, 8'd49, 8'd48,
		8'd47, 8'd47, 8'd46, 8'd45, 8'd45, 8'd44, 8'd43, 8'd43,
		8'd42, 8'd42, 8'd41, 8'd41, 8'd40, 8'd40, 8'd39, 8'd39,
		8'd38, 8'd38, 8'd37, 8'd37, 8'd36, 8'd36, 8'd35, 8'd35,
		8'd34, 8'd34, 8'd34, 8'd33, 8'd33, 8'd33, 8'd32, 8'd32,
		8'd31, 8'd31, 8'd31, 8'd30, 8'd30, 8'd30, 8'd29, 8'd29,
		8'd29, 8'd28, 8'd28, 8'd28, 8'd27, 8'd27, 8'd27, 8'd27,
		8'd26, 8'd26, 8'd26, 8'd25, 8'd25, 8'd25, 8'd25, 8'd24,
		8'd24, 8'd24, 8'd24, 8'd23, 8'd23, 8'd23, 8'd23, 8'd22,
		8'd22, 8'd22, 8'd22, 8'd21, 8'd21, 8'd21, 8'd21, 8'd20,
		8'd20, 8'd20, 8'd20, 8'd20, 8'd19, 8'd19, 8'd19, 8'd19,
		8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd17, 8'd17, 8'd17,
		8'd17, 8'd17, 8'd17, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
		8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd15, 8'd14, 8'd14,
		8'd14, 8'd14, 8'd14, 8'd14, 8'd13, 8'd13, 8'd13, 8'd13,
		8'd13, 8'd13, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd12,
		8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11, 8'd10,
		8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd9, 8'd9,
		8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd8, 8'd8, 8'd8,
		8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd7, 8'd7, 8'd7,
		8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd6, 8'd6, 8'd6,
		8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd5, 8'd5, 8'd5,
		8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd4, 8'd4,
		8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd3,
		8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
		8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
		8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
	};

endpackage

// ----- rtl/core/voice_register_write_encoder_core.sv -----
// Voice register write encoder.
//
// Input channel (in_valid / in_ready): one request per voice to play: channel,
// sample address, format, length, loop flag, frequency, volume, pan, key-on.
// Output channel (out_valid / out_ready): a run of register writes, each with
// reg_offset, write_data, byte_access and last_write; last_write marks the end.
// A request for a voice at or above VOICES is taken and dropped: no writes.
//
// Sequence: a request is taken only while the sequencer is idle. The pitch
// unit then runs the octave search and the restoring division, both on one
// shared subtractor, and hands over the word through a register. Writes then
// leave one per cycle while the receiver does not stall, 11 or 12 of them.
//
// A stalled receiver holds the output register; the sequencer waits with it,
// and no write is lost or repeated. in_ready returns once the last write is
// loaded into the output register, while that write may still be waiting.
// Reset clears the sequencer, the pitch unit and out_valid; no clearing pass.
module voice_register_write_encoder_core #(
	parameter int VOICES      = 64,
	parameter int MAX_SAMPLES = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [5:0]         channel,
	input  logic [22:0]        sample_addr,
	input  logic [1:0]         sample_format,
	input  logic [31:0]        sample_count,
	input  logic               loop_enable,
	input  logic [21:0]        frequency,
	input  logic signed [15:0] volume,
	input  logic signed [15:0] pan_position,
	input  logic               key_on,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [13:0]        reg_offset,
	output logic [31:0]        write_data,
	output logic               byte_access,
	output logic               last_write
);

	import vrwe_pkg::*;

	top_state_t state_q, state_d;

	// Request fields held for the whole sequence
	logic [5:0]  chan_q;
	logic [15:0] addr_lo_q;
	logic [15:0] ctrl_q;
	logic [15:0] length_q;
	logic [4:0]  pan_q;
	logic [7:0]  atten_q;
	logic        key_q;
	logic [31:0] pitch_q;
	write_idx_t  idx_q;

	// Output register
	logic        out_valid_q;
	logic [13:0] reg_offset_q;
	logic [31:0] write_data_q;
	logic        byte_access_q;
	logic        last_write_q;

	logic        in_fire;
	logic        chan_ok;
	logic        pitch_start;
	logic        load;
	logic [6:0]  sel_slot;
	logic [31:0] sel_data;
	logic        sel_byte;
	logic        sel_last;
	logic [7:0]  vol_clamped;
	logic [7:0]  pan_clamped;
	logic [4:0]  pan_code;
	logic [15:0] length_clamped;
	pitch_rsp_t  pitch_rsp;

	// Clamp a signed 16-bit value to 0..255
	function automatic logic [7:0] clamp_byte(input logic signed [15:0] v);
		logic [7:0] r;
		if (v[15])
			r = 8'd0;
		else if (v[14:8] != '0)
			r = 8'd255;
		else
			r = v[7:0];
		return r;
	endfunction

	assign in_ready    = (state_q == TOP_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign chan_ok     = ({1'b0, channel} < 7'(VOICES));
	assign pitch_start = in_fire && chan_ok;

	assign vol_clamped = clamp_byte(volume);
	assign pan_clamped = clamp_byte(pan_position);

	// Centre is silent-offset zero; left half gets the left flag and a step count
	always_comb begin
		if (pan_clamped == 8'h80)
			pan_code = 5'd0;
		else if (!pan_clamped[7])
			pan_code = {1'b1, 4'((8'h7f - pan_clamped) >> 3)};
		else
			pan_code = {1'b0, 4'((pan_clamped - 8'h80) >> 3)};
	end

	assign length_clamped = (sample_count > 32'(MAX_SAMPLES)) ? 16'(MAX_SAMPLES)
	                                                          : sample_count[15:0];

	vrwe_pitch u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pitch_start),
		.freq   (frequency),
		.rsp    (pitch_rsp)
	);

	// Capture the request and precompute the per-voice fields
	always_ff @(posedge clk) begin
		if (pitch_start) begin
			chan_q    <= channel;
			addr_lo_q <= sample_addr[15:0];
			ctrl_q    <= {6'b0, loop_enable, sample_format, sample_addr[22:16]};
			length_q  <= length_clamped;
			pan_q     <= pan_code;
			atten_q   <= ATTEN_TABLE[vol_clamped];
			key_q     <= key_on;
		end
		if (state_q == TOP_PITCH && pitch_rsp.done)
			pitch_q <= pitch_rsp.word;
	end

	// Pick the write at the current index
	always_comb begin
		sel_slot = SLOT_CONTROL;
		sel_data = '0;
		sel_byte = 1'b0;
		unique case (idx_q)
			W_KEY_OFF: begin
				sel_slot = SLOT_CONTROL;
				sel_data = KEY_OFF_DATA;
			end
			W_LOOP_START: begin
				sel_slot = SLOT_LOOP;
				sel_data = '0;
			end
			W_LENGTH: begin
				sel_slot = SLOT_LENGTH;
				sel_data = {16'b0, length_q};
			end
			W_PITCH: begin
				sel_slot = SLOT_PITCH;
				sel_data = pitch_q;
			end
			W_PAN: begin
				sel_slot = SLOT_PAN;
				sel_data = {27'b0, pan_q};
				sel_byte = 1'b1;
			end
			W_SEND: begin
				sel_slot = SLOT_SEND;
				sel_data = SEND_LEVEL;
				sel_byte = 1'b1;
			end
			W_FILTER: begin
				sel_slot = SLOT_FILTER;
				sel_data = FILTER_SETTING;
				sel_byte = 1'b1;
			end
			W_VOLUME: begin
				sel_slot = SLOT_VOLUME;
				sel_data = {24'b0, atten_q};
				sel_byte = 1'b1;
			end
			W_ENVELOPE: begin
				sel_slot = SLOT_ENV;
				sel_data = ENV_SETTING;
			end
			W_ADDR_LO: begin
				sel_slot = SLOT_ADDR_LO;
				sel_data = {16'b0, addr_lo_q};
			end
			W_CONTROL: begin
				sel_slot = SLOT_CONTROL;
				sel_data = {16'b0, ctrl_q};
			end
			W_KEY_ON: begin
				// Readback of control assumed equal to the last write
				sel_slot = SLOT_CONTROL;
				sel_data = {16'b0, ctrl_q | KEY_ON_BITS};
			end
			default: begin
				sel_slot = SLOT_CONTROL;
				sel_data = '0;
			end
		endcase
	end

	assign sel_last = (idx_q == W_KEY_ON) || (idx_q == W_CONTROL && !key_q);
	assign load     = (state_q == TOP_EMIT) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= TOP_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (pitch_start) state_d = TOP_PITCH;
			end
			TOP_PITCH: begin
				if (pitch_rsp.done) state_d = TOP_EMIT;
			end
			TOP_EMIT: begin
				if (load && sel_last) state_d = TOP_IDLE;
			end
			default: state_d = TOP_IDLE;
		endcase
	end

	// Advance the write index on each load; restart it for every request
	always_ff @(posedge clk) begin
		if (pitch_start)
			idx_q <= W_KEY_OFF;
		else if (load && !sel_last)
			idx_q <= write_idx_t'(idx_q + 4'd1);
	end

	// Output register: load a new write, or drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			reg_offset_q  <= {1'b0, chan_q, sel_slot};
			write_data_q  <= sel_data;
			byte_access_q <= sel_byte;
			last_write_q  <= sel_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign reg_offset  = reg_offset_q;
	assign write_data  = write_data_q;
	assign byte_access = byte_access_q;
	assign last_write  = last_write_q;

	// The pitch word only arrives while the sequencer waits for it
	a_pitch_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pitch_rsp.done |-> state_q == TOP_PITCH)
		else $error("pitch word arrived outside the wait state");

	// Loading the final write returns the sequencer to idle
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load && sel_last) |=> (state_q == TOP_IDLE && out_valid && last_write))
		else $error("last write did not end the sequence");

	// Byte writes only target the pan, send, filter and volume slots
	a_byte_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_access) |->
			(reg_offset[6:0] == SLOT_PAN || reg_offset[6:0] == SLOT_SEND ||
			 reg_offset[6:0] == SLOT_FILTER || reg_offset[6:0] == SLOT_VOLUME))
		else $error("byte write to a word slot");

endmodule

// ----- rtl/core/vrwe_sub_unit.sv -----
module vrwe_sub_unit (
	input  logic [23:0] a,
	input  logic [22:0] b,
	output logic [23:0] diff,
	output logic        ge
);

	logic borrow;

	// One subtractor serves both the octave compare and the division step
	assign {borrow, diff} = {1'b0, a} - {2'b00, b};
	assign ge = ~borrow;

endmodule

// ----- rtl/core/vrwe_pitch.sv -----
module vrwe_pitch (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [21:0]         freq,
	output vrwe_pkg::pitch_rsp_t rsp
);

	import vrwe_pkg::*;

	localparam logic [22:0]        BASE_TOP     = 23'd5644800;
	localparam logic [21:0]        DEFAULT_FREQ = 22'd44100;
	localparam logic signed [3:0]  OCT_MAX      = 4'sd7;
	localparam logic signed [3:0]  OCT_MIN      = -4'sd8;
	localparam int                 DIV_STEPS    = 12;
	localparam logic [3:0]         LAST_STEP    = 4'(DIV_STEPS - 1);

	pitch_state_t state_q, state_d;

	logic [21:0]        f_q;
	logic [22:0]        base_q;
	logic signed [3:0]  oct_q;
	logic [22:0]        rem_q;
	logic [11:0]        dbits_q;
	logic [9:0]         quo_q;
	logic [3:0]         step_q;
	logic               done_q;

	logic [23:0] sub_a;
	logic [23:0] sub_diff;
	logic        sub_ge;
	logic        oct_step;
	logic        oct_exit;
	logic        div_step;
	logic        div_last;

	vrwe_sub_unit u_sub (
		.a    (sub_a),
		.b    (base_q),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PIT_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= div_last;
		end
	end

	always_comb begin
		state_d  = state_q;
		sub_a    = {2'b00, f_q};
		oct_step = 1'b0;
		oct_exit = 1'b0;
		div_step = 1'b0;
		div_last = 1'b0;
		unique case (state_q)
			PIT_IDLE: begin
				if (start) state_d = PIT_OCT;
			end
			PIT_OCT: begin
				// Halve the base while the frequency lies below it
				if (!sub_ge && oct_q != OCT_MIN) begin
					oct_step = 1'b1;
				end else begin
					oct_exit = 1'b1;
					state_d  = PIT_DIV;
				end
			end
			PIT_DIV: begin
				sub_a    = {rem_q, dbits_q[11]};
				div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					div_last = 1'b1;
					state_d  = PIT_IDLE;
				end
			end
			default: state_d = PIT_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == PIT_IDLE && start) begin
			f_q    <= (freq == '0) ? DEFAULT_FREQ : freq;
			base_q <= BASE_TOP;
			oct_q  <= OCT_MAX;
		end
		if (oct_step) begin
			base_q <= base_q >> 1;
			oct_q  <= oct_q - 4'sd1;
		end
		if (oct_exit) begin
			// Frequency is below four times the base, so f/4 seeds the remainder
			rem_q   <= {3'b000, f_q[21:2]};
			dbits_q <= {f_q[1:0], 10'b0};
			step_q  <= '0;
		end
		if (div_step) begin
			rem_q   <= sub_ge ? sub_diff[22:0] : sub_a[22:0];
			dbits_q <= {dbits_q[10:0], 1'b0};
			quo_q   <= {quo_q[8:0], sub_ge};
			step_q  <= step_q + 4'd1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.word = {{17{oct_q[3]}}, oct_q, 1'b0, quo_q};

endmodule
